/* hw/rtl/ilbc_pkg.sv */
package ilbc_pkg;

   localparam int MaxTuplesDefault = 8;
   localparam int KeyW             = 64;
   localparam int PrioW            = 32;
   localparam int SlotOutW         = 3;

   typedef enum logic [1:0] {
      CLASS_REQUEST    = 2'd0,
      CLASS_INDICATION = 2'd1,
      CLASS_SUCCESS    = 2'd2,
      CLASS_ERROR      = 2'd3
   } msg_class_type;

   // external authentication verdict; any other code means cannot check
   localparam logic [1:0] AUTH_OK           = 2'd0;
   localparam logic [1:0] AUTH_UNAUTHORIZED = 2'd1;

   typedef enum logic [2:0] {
      REPLY_NONE    = 3'd0,
      REPLY_SUCCESS = 3'd1,
      REPLY_400     = 3'd2,
      REPLY_401     = 3'd3,
      REPLY_487     = 3'd4
   } reply_type;

   typedef enum logic [1:0] {
      ICE_NEW       = 2'd0,
      ICE_CONNECTED = 2'd1,
      ICE_COMPLETED = 2'd2
   } ice_state_type;

   typedef enum logic [1:0] {
      EVENT_NONE      = 2'd0,
      EVENT_CONNECTED = 2'd1,
      EVENT_COMPLETED = 2'd2
   } state_event_type;

   typedef struct packed {
      msg_class_type     msg_class;
      logic              is_binding;
      logic              has_fingerprint;
      logic              has_integrity;
      logic [PrioW-1:0]  priority_value;
      logic              has_username;
      logic [1:0]        auth_result;
      logic              ice_controlled;
      logic              use_candidate;
      logic [KeyW-1:0]   tuple_key;
   } req_type;

   typedef struct packed {
      reply_type             reply;
      ice_state_type         ice_state_out;
      state_event_type       state_event;
      logic [SlotOutW-1:0]   selected_slot;
      logic                  selected_changed;
      logic                  tuple_added;
      logic                  table_full;
   } rsp_type;

endpackage

/* hw/rtl/ilbc_req_if.sv */
interface ilbc_req_if;
   import ilbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        msg_class;
   logic              is_binding;
   logic              has_fingerprint;
   logic              has_integrity;
   logic [PrioW-1:0]  priority_value;
   logic              has_username;
   logic [1:0]        auth_result;
   logic              ice_controlled;
   logic              use_candidate;
   logic [KeyW-1:0]   tuple_key;

   modport source (
      output valid, msg_class, is_binding, has_fingerprint, has_integrity,
             priority_value, has_username, auth_result, ice_controlled,
             use_candidate, tuple_key,
      input  ready
   );

   modport sink (
      input  valid, msg_class, is_binding, has_fingerprint, has_integrity,
             priority_value, has_username, auth_result, ice_controlled,
             use_candidate, tuple_key,
      output ready
   );

endinterface

/* hw/rtl/ilbc_rsp_if.sv */
interface ilbc_rsp_if;
   import ilbc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [2:0]            reply;
   logic [1:0]            ice_state_out;
   logic [1:0]            state_event;
   logic [SlotOutW-1:0]   selected_slot;
   logic                  selected_changed;
   logic                  tuple_added;
   logic                  table_full;

   modport source (
      output valid, reply, ice_state_out, state_event, selected_slot,
             selected_changed, tuple_added, table_full,
      input  ready
   );

   modport sink (
      input  valid, reply, ice_state_out, state_event, selected_slot,
             selected_changed, tuple_added, table_full,
      output ready
   );

endinterface

/* hw/rtl/ice_lite_binding_check.sv */
// ice-lite stun binding responder: every req_ beat is the flag summary of one parsed stun
// message plus its transport tuple key, and yields exactly one rsp_ beat with the reply code
// (none, success, 400, 401, 487), the ice state after the message, a state event, the selected
// tuple slot and the table flags. a beat lands in an input register, is checked and applied in
// one pass of logic, and lands in the result register; one beat is taken every cycle while
// rsp_ ready keeps the result register draining; the tuple table holds MAX_TUPLES keys in
// flip-flops that are all compared against the incoming key in the same cycle, with the
// lowest free slot picked from the valid bits alongside. the input register frees up whenever
// the result register is empty or drained; while a result waits, one more request is held in
// the input register and then req_ ready drops until the result is taken. reset
// clears ice state, selection and the table valid bits at once; keys are kept without reset
// and only read behind a valid bit
module ice_lite_binding_check #(
   parameter int MAX_TUPLES = ilbc_pkg::MaxTuplesDefault
) (
   input logic         clock,
   input logic         reset,
   ilbc_req_if.sink    req_chan,
   ilbc_rsp_if.source  rsp_chan
);
   import ilbc_pkg::*;

   localparam int SlotW = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;

   // pipeline control
   logic      in_valid_ff, in_valid_in;
   logic      out_valid_ff, out_valid_in;
   logic      advance;
   req_type   in_data_ff, in_data_in;
   rsp_type   out_data_ff, out_data_in;

   // block state
   ice_state_type            ice_state_ff, ice_state_in;
   logic [MAX_TUPLES-1:0]    tuple_valid_ff, tuple_valid_in;
   logic [KeyW-1:0]          tuple_key_ff [MAX_TUPLES];
   logic [SlotW-1:0]         sel_idx_ff, sel_idx_in;
   logic                     has_sel_ff, has_sel_in;

   // per-beat decode
   reply_type                reply_code;
   logic                     success;
   logic [MAX_TUPLES-1:0]    match_vec;
   logic                     hit;
   logic [SlotW-1:0]         hit_idx;
   logic [MAX_TUPLES-1:0]    free_vec;
   logic [MAX_TUPLES-1:0]    free_onehot;
   logic [SlotW-1:0]         free_idx;
   logic                     no_room;
   logic                     step_ok;
   logic                     add_tuple;
   logic [SlotW-1:0]         slot;
   logic                     do_select;
   logic                     sel_change;
   ice_state_type            ice_state_nx;

   // ---------------------------------------------------------------- handshake

   // input register moves on when the result register is empty or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_comb begin
      in_data_in.msg_class       = msg_class_type'(req_chan.msg_class);
      in_data_in.is_binding      = req_chan.is_binding;
      in_data_in.has_fingerprint = req_chan.has_fingerprint;
      in_data_in.has_integrity   = req_chan.has_integrity;
      in_data_in.priority_value  = req_chan.priority_value;
      in_data_in.has_username    = req_chan.has_username;
      in_data_in.auth_result     = req_chan.auth_result;
      in_data_in.ice_controlled  = req_chan.ice_controlled;
      in_data_in.use_candidate   = req_chan.use_candidate;
      in_data_in.tuple_key       = req_chan.tuple_key;
   end

   // ---------------------------------------------------------------- message checks

   // first failing check decides the reply
   always_comb begin
      reply_code = REPLY_SUCCESS;
      if (!in_data_ff.is_binding) begin
         reply_code = (in_data_ff.msg_class == CLASS_REQUEST) ? REPLY_400 : REPLY_NONE;
      end else if (!in_data_ff.has_fingerprint && in_data_ff.msg_class != CLASS_INDICATION) begin
         // missing fingerprint is only tolerated on indications
         reply_code = (in_data_ff.msg_class == CLASS_REQUEST) ? REPLY_400 : REPLY_NONE;
      end else if (in_data_ff.msg_class != CLASS_REQUEST) begin
         reply_code = REPLY_NONE;
      end else if (!in_data_ff.has_integrity || in_data_ff.priority_value == '0 ||
                   !in_data_ff.has_username) begin
         reply_code = REPLY_400;
      end else begin
         unique case (in_data_ff.auth_result)
            AUTH_OK:           reply_code = in_data_ff.ice_controlled ? REPLY_487
                                                                      : REPLY_SUCCESS;
            AUTH_UNAUTHORIZED: reply_code = REPLY_401;
            default:           reply_code = REPLY_400;  // cannot check, or unknown code
         endcase
      end
   end

   assign success = (reply_code == REPLY_SUCCESS);

   // ---------------------------------------------------------------- tuple table lookup

   // valid keys are unique, so at most one slot matches and the index can be or-encoded
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < MAX_TUPLES; i++) begin
         match_vec[i] = tuple_valid_ff[i] && (tuple_key_ff[i] == in_data_ff.tuple_key);
         if (match_vec[i]) begin
            hit_idx = hit_idx | SlotW'(i);
         end
      end
   end

   assign hit = |match_vec;

   // lowest free slot as a one-hot, then encoded
   assign free_vec    = ~tuple_valid_ff;
   assign free_onehot = free_vec & (~free_vec + MAX_TUPLES'(1));

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < MAX_TUPLES; i++) begin
         if (free_onehot[i]) begin
            free_idx = free_idx | SlotW'(i);
         end
      end
   end

   assign no_room    = !hit && (&tuple_valid_ff);
   assign step_ok    = success && !no_room;
   assign add_tuple  = step_ok && !hit;
   assign slot       = hit ? hit_idx : free_idx;
   assign do_select  = (ice_state_ff == ICE_NEW) || in_data_ff.use_candidate;
   assign sel_change = step_ok && do_select && (!has_sel_ff || sel_idx_ff != slot);

   // ---------------------------------------------------------------- next state

   always_comb begin
      ice_state_nx = ice_state_ff;
      if (step_ok) begin
         unique case (ice_state_ff)
            ICE_NEW:       ice_state_nx = in_data_ff.use_candidate ? ICE_COMPLETED
                                                                   : ICE_CONNECTED;
            ICE_CONNECTED: ice_state_nx = in_data_ff.use_candidate ? ICE_COMPLETED
                                                                   : ICE_CONNECTED;
            ICE_COMPLETED: ice_state_nx = ICE_COMPLETED;
            default:       ice_state_nx = ice_state_ff;
         endcase
      end
   end

   always_comb begin
      ice_state_in   = ice_state_ff;
      tuple_valid_in = tuple_valid_ff;
      sel_idx_in     = sel_idx_ff;
      has_sel_in     = has_sel_ff;
      if (advance) begin
         ice_state_in = ice_state_nx;
         if (add_tuple) begin
            tuple_valid_in = tuple_valid_ff | free_onehot;
         end
         if (sel_change) begin
            sel_idx_in = slot;
            has_sel_in = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- result beat

   always_comb begin
      out_data_in.reply         = reply_code;
      out_data_in.ice_state_out = ice_state_nx;
      if (ice_state_nx == ice_state_ff) begin
         out_data_in.state_event = EVENT_NONE;
      end else if (ice_state_nx == ICE_CONNECTED) begin
         out_data_in.state_event = EVENT_CONNECTED;
      end else begin
         out_data_in.state_event = EVENT_COMPLETED;
      end
      // slot field shows the low bits of the selection after this beat, zero when none
      if (sel_change) begin
         out_data_in.selected_slot = SlotOutW'(slot);
      end else if (has_sel_ff) begin
         out_data_in.selected_slot = SlotOutW'(sel_idx_ff);
      end else begin
         out_data_in.selected_slot = '0;
      end
      out_data_in.selected_changed = sel_change;
      out_data_in.tuple_added      = add_tuple;
      out_data_in.table_full       = success && no_room;
   end

   // ---------------------------------------------------------------- registers

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         ice_state_ff   <= ICE_NEW;
         tuple_valid_ff <= '0;
         sel_idx_ff     <= '0;
         has_sel_ff     <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         ice_state_ff   <= ice_state_in;
         tuple_valid_ff <= tuple_valid_in;
         sel_idx_ff     <= sel_idx_in;
         has_sel_ff     <= has_sel_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_data_ff <= in_data_in;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
      if (advance && add_tuple) begin
         tuple_key_ff[free_idx] <= in_data_ff.tuple_key;
      end
   end

   // ---------------------------------------------------------------- outputs

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.reply            = out_data_ff.reply;
   assign rsp_chan.ice_state_out    = out_data_ff.ice_state_out;
   assign rsp_chan.state_event      = out_data_ff.state_event;
   assign rsp_chan.selected_slot    = out_data_ff.selected_slot;
   assign rsp_chan.selected_changed = out_data_ff.selected_changed;
   assign rsp_chan.tuple_added      = out_data_ff.tuple_added;
   assign rsp_chan.table_full       = out_data_ff.table_full;

endmodule

/* sim/ilbc_reply_checker.sv */
`timescale 1ns / 100ps

// watches both channels, keeps its own copy of the responder state and compares every
// rsp_ beat against the oldest predicted reply
module ilbc_reply_checker #(
   parameter int MaxTuples = ilbc_pkg::MaxTuplesDefault
) (
   input  logic  clock,
   input  logic  reset,
   ilbc_req_if   req_chan,
   ilbc_rsp_if   rsp_chan,
   output int    fail_count,
   output int    due_count
);
   import ilbc_pkg::*;

   // mirrored responder state
   ice_state_type   ice_now;
   logic [KeyW-1:0] key_store [MaxTuples];
   logic            key_used  [MaxTuples];
   int              sel_idx;
   bit              have_sel;

   rsp_type replies_due [$];
   rsp_type want;
   req_type msg;
   int      mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [3:0] got,
                              input logic [3:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
   endtask

   // reply for one parsed message; updates the mirrored state on success
   function automatic rsp_type answer_message(input req_type m);
      rsp_type   r;
      reply_type refusal;
      int        hit;
      int        spare;
      r = '0;
      hit = -1;
      spare = -1;
      refusal = (m.msg_class == CLASS_REQUEST) ? REPLY_400 : REPLY_NONE;
      if (!m.is_binding)
         r.reply = refusal;
      else if (!m.has_fingerprint && m.msg_class != CLASS_INDICATION)
         r.reply = refusal;
      else if (m.msg_class != CLASS_REQUEST)
         r.reply = REPLY_NONE;
      else if (!m.has_integrity || m.priority_value == '0 || !m.has_username)
         r.reply = REPLY_400;
      else if (m.auth_result == AUTH_UNAUTHORIZED)
         r.reply = REPLY_401;
      else if (m.auth_result != AUTH_OK)
         r.reply = REPLY_400;
      else if (m.ice_controlled)
         r.reply = REPLY_487;
      else begin
         r.reply = REPLY_SUCCESS;
         for (int i = 0; i < MaxTuples; i++) begin
            if (hit < 0 && key_used[i] && key_store[i] == m.tuple_key) hit = i;
            if (spare < 0 && !key_used[i]) spare = i;
         end
         if (hit < 0 && spare < 0) begin
            r.table_full = 1'b1;
         end else begin
            if (hit < 0) begin
               hit = spare;
               key_store[hit] = m.tuple_key;
               key_used[hit] = 1'b1;
               r.tuple_added = 1'b1;
            end
            if ((ice_now == ICE_NEW || m.use_candidate) && (!have_sel || sel_idx != hit)) begin
               sel_idx = hit;
               have_sel = 1'b1;
               r.selected_changed = 1'b1;
            end
            if (ice_now == ICE_NEW) begin
               ice_now = m.use_candidate ? ICE_COMPLETED : ICE_CONNECTED;
               r.state_event = m.use_candidate ? EVENT_COMPLETED : EVENT_CONNECTED;
            end else if (ice_now == ICE_CONNECTED && m.use_candidate) begin
               ice_now = ICE_COMPLETED;
               r.state_event = EVENT_COMPLETED;
            end
         end
      end
      r.ice_state_out = ice_now;
      r.selected_slot = have_sel ? SlotOutW'(sel_idx) : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         replies_due.delete();
         ice_now = ICE_NEW;
         sel_idx = 0;
         have_sel = 1'b0;
         for (int i = 0; i < MaxTuples; i++) key_used[i] = 1'b0;
      end else begin
         // retire first: a reply never leaves in the cycle its message arrives
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("result beat with no message outstanding");
            end else begin
               want = replies_due.pop_front();
               check_field("reply", 4'(rsp_chan.reply), 4'(want.reply));
               check_field("ice_state_out", 4'(rsp_chan.ice_state_out),
                           4'(want.ice_state_out));
               check_field("state_event", 4'(rsp_chan.state_event), 4'(want.state_event));
               check_field("selected_slot", 4'(rsp_chan.selected_slot),
                           4'(want.selected_slot));
               check_field("selected_changed", 4'(rsp_chan.selected_changed),
                           4'(want.selected_changed));
               check_field("tuple_added", 4'(rsp_chan.tuple_added), 4'(want.tuple_added));
               check_field("table_full", 4'(rsp_chan.table_full), 4'(want.table_full));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            msg.msg_class       = msg_class_type'(req_chan.msg_class);
            msg.is_binding      = req_chan.is_binding;
            msg.has_fingerprint = req_chan.has_fingerprint;
            msg.has_integrity   = req_chan.has_integrity;
            msg.priority_value  = req_chan.priority_value;
            msg.has_username    = req_chan.has_username;
            msg.auth_result     = req_chan.auth_result;
            msg.ice_controlled  = req_chan.ice_controlled;
            msg.use_candidate   = req_chan.use_candidate;
            msg.tuple_key       = req_chan.tuple_key;
            replies_due.push_back(answer_message(msg));
         end
      end
      due_count  <= replies_due.size();
      fail_count <= mismatches;
   end

endmodule

/* sim/tb_ice_lite_binding_check.sv */
`timescale 1ns / 100ps

// stimulus and verdict for the binding responder; all checking lives in the reply checker
module tb_ice_lite_binding_check;
   import ilbc_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   due_count;

   ilbc_req_if req_chan ();
   ilbc_rsp_if rsp_chan ();

   ice_lite_binding_check u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ilbc_reply_checker u_reply_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .due_count  (due_count)
   );

   // keys reused across the run: two extremes plus random ones, more than the table holds
   logic [KeyW-1:0] key_pool [12];
   int              quiet_run = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // a message that passes every check; priority is never zero
   function automatic req_type well_formed(input logic [KeyW-1:0] key, input logic cand);
      req_type m;
      m.msg_class       = CLASS_REQUEST;
      m.is_binding      = 1'b1;
      m.has_fingerprint = 1'b1;
      m.has_integrity   = 1'b1;
      m.priority_value  = $urandom();
      if (m.priority_value == '0) m.priority_value = 1;
      m.has_username    = 1'b1;
      m.auth_result     = AUTH_OK;
      m.ice_controlled  = 1'b0;
      m.use_candidate   = cand;
      m.tuple_key       = key;
      return m;
   endfunction

   function automatic logic [KeyW-1:0] fresh_key();
      return {$urandom(), $urandom()};
   endfunction

   // idle a random while, then hold one beat until it is taken
   task automatic offer(input req_type m);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_run > 0) begin
         quiet_run--;
         gap = 0;
      end else if (roll < 2) begin
         // back-to-back stretch with no sender gaps
         quiet_run = $urandom_range(20, 60);
         gap = 0;
      end else if (roll < 70) begin
         gap = 0;
      end else if (roll < 95) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.msg_class       <= m.msg_class;
      req_chan.is_binding      <= m.is_binding;
      req_chan.has_fingerprint <= m.has_fingerprint;
      req_chan.has_integrity   <= m.has_integrity;
      req_chan.priority_value  <= m.priority_value;
      req_chan.has_username    <= m.has_username;
      req_chan.auth_result     <= m.auth_result;
      req_chan.ice_controlled  <= m.ice_controlled;
      req_chan.use_candidate   <= m.use_candidate;
      req_chan.tuple_key       <= m.tuple_key;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // wait until the checker has seen every reply; due_count is registered in the checker
   task automatic drain_replies();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   // result side: random stalls, runs of steady ready, and two long hold-offs
   initial begin
      int iter;
      int run;
      int stall;
      iter = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         iter++;
         if (iter == 10 || iter == 80) begin
            // long hold-off so the block fills and stops taking requests
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
         rsp_chan.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         rsp_chan.ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
   end

   initial begin
      req_type m;
      int      roll;
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.msg_class       <= '0;
      req_chan.is_binding      <= 1'b0;
      req_chan.has_fingerprint <= 1'b0;
      req_chan.has_integrity   <= 1'b0;
      req_chan.priority_value  <= '0;
      req_chan.has_username    <= 1'b0;
      req_chan.auth_result     <= '0;
      req_chan.ice_controlled  <= 1'b0;
      req_chan.use_candidate   <= 1'b0;
      req_chan.tuple_key       <= '0;
      key_pool[0] = '1;
      key_pool[1] = '0;
      for (int i = 2; i < 12; i++) key_pool[i] = fresh_key();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: every check in order, while the state is still new
      m = well_formed(fresh_key(), 1'b0); m.is_binding = 1'b0; offer(m);
      m = well_formed(fresh_key(), 1'b1); m.is_binding = 1'b0;
      m.msg_class = CLASS_INDICATION; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.has_fingerprint = 1'b0; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.has_fingerprint = 1'b0;
      m.msg_class = CLASS_SUCCESS; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.has_fingerprint = 1'b0;
      m.msg_class = CLASS_ERROR; offer(m);
      // indication without fingerprint gets past that check, then is ignored
      m = well_formed(fresh_key(), 1'b0); m.has_fingerprint = 1'b0;
      m.msg_class = CLASS_INDICATION; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.has_integrity = 1'b0; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.priority_value = '0; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.has_username = 1'b0; offer(m);
      m = well_formed(fresh_key(), 1'b1); m.auth_result = AUTH_UNAUTHORIZED; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.auth_result = 2'd2; offer(m);
      // auth code three has no meaning and counts as cannot check
      m = well_formed(fresh_key(), 1'b0); m.auth_result = 2'd3; offer(m);
      m = well_formed(fresh_key(), 1'b0); m.ice_controlled = 1'b1; offer(m);

      // first success: new to connected, all-ones key lands in slot 0 and is selected
      m = well_formed(key_pool[0], 1'b0); m.priority_value = '1; offer(m);
      // connected without use-candidate: zero key is stored but not selected
      m = well_formed(key_pool[1], 1'b0); m.priority_value = 1; offer(m);
      // same tuple with use-candidate: completed, selection unchanged
      offer(well_formed(key_pool[0], 1'b1));
      // completed: use-candidate moves the selection
      offer(well_formed(key_pool[1], 1'b1));
      // fill the rest of the table
      for (int i = 2; i < 8; i++) offer(well_formed(key_pool[i], 1'b0));
      // table full: new key with use-candidate is dropped, selection kept
      offer(well_formed(key_pool[8], 1'b1));
      offer(well_formed(key_pool[3], 1'b1));

      // random: mostly good requests over the key pool, the rest broken or raw
      for (int n = 0; n < 1125; n++) begin
         if (n == 560) drain_replies();
         m = well_formed(key_pool[$urandom_range(0, 11)], 1'($urandom_range(0, 1)));
         roll = $urandom_range(0, 99);
         if (roll >= 65) begin
            case ($urandom_range(0, 8))
               0: m.msg_class = msg_class_type'($urandom_range(1, 3));
               1: begin
                  m.is_binding = 1'b0;
                  m.msg_class = msg_class_type'($urandom_range(0, 3));
               end
               2: begin
                  m.has_fingerprint = 1'b0;
                  m.msg_class = msg_class_type'($urandom_range(0, 3));
               end
               3: m.has_integrity = 1'b0;
               4: m.priority_value = '0;
               5: m.has_username = 1'b0;
               6: m.auth_result = 2'($urandom_range(1, 3));
               7: m.ice_controlled = 1'b1;
               default: begin
                  m.msg_class       = msg_class_type'($urandom_range(0, 3));
                  m.is_binding      = 1'($urandom_range(0, 1));
                  m.has_fingerprint = 1'($urandom_range(0, 1));
                  m.has_integrity   = 1'($urandom_range(0, 1));
                  m.priority_value  = $urandom();
                  m.has_username    = 1'($urandom_range(0, 1));
                  m.auth_result     = 2'($urandom_range(0, 3));
                  m.ice_controlled  = 1'($urandom_range(0, 1));
                  m.tuple_key       = fresh_key();
               end
            endcase
         end
         offer(m);
      end

      drain_replies();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* ice_lite_binding_check.f */
hw/rtl/ilbc_pkg.sv
hw/rtl/ilbc_req_if.sv
hw/rtl/ilbc_rsp_if.sv
hw/rtl/ice_lite_binding_check.sv
sim/ilbc_reply_checker.sv
sim/tb_ice_lite_binding_check.sv
